>>> rtl/core/pss_pkg.sv
// package for the process state scheduler: sizes, codes and shared types
package pss_pkg;

   localparam int MaxProcs  = 16;
   localparam int SlotW     = $clog2(MaxProcs);
   localparam int CountW    = $clog2(MaxProcs + 1);

   typedef enum logic [2:0] {
      REQ_CREATE  = 3'd0,
      REQ_TICK    = 3'd1,
      REQ_BLOCK   = 3'd2,
      REQ_UNBLOCK = 3'd3,
      REQ_DONE    = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      STAT_OK         = 3'd0,
      STAT_NO_READY   = 3'd1,
      STAT_NO_RUNNING = 3'd2,
      STAT_NO_MATCH   = 3'd3,
      STAT_TABLE_FULL = 3'd4
   } status_code_type;

   typedef enum logic [1:0] {
      SLOT_FREE    = 2'd0,
      SLOT_READY   = 2'd1,
      SLOT_RUNNING = 2'd2,
      SLOT_BLOCKED = 2'd3
   } slot_state_type;

   // search request from the sequencer to the slot scanner
   typedef struct packed {
      logic        start;
      logic        find_free;
      logic [15:0] event_id;
      logic [15:0] block_seq;
   } scan_req_type;

   typedef struct packed {
      logic             done;
      logic             found;
      logic [SlotW-1:0] slot;
   } scan_rsp_type;

endpackage

>>> rtl/core/pss_scan.sv
// slot scanner: walks the slot table one entry a cycle with one shared age compare
module pss_scan
   import pss_pkg::*;
(
   input  logic                                clock,
   input  logic                                reset,
   input  scan_req_type                        scan_req,
   input  slot_state_type [MaxProcs-1:0]       slot_state,
   output logic [SlotW-1:0]                    rd_slot,
   input  logic [15:0]                         rd_event,
   input  logic [15:0]                         rd_stamp,
   output scan_rsp_type                        scan_rsp
);

   logic              busy_ff, busy_in;
   logic [SlotW-1:0]  idx_ff, idx_in;
   logic              found_ff, found_in;
   logic [SlotW-1:0]  best_ff, best_in;
   logic [15:0]       age_ff, age_in;
   logic              free_mode_ff, free_mode_in;
   logic [15:0]       ev_ff, ev_in, seq_ff, seq_in;
   logic              last;
   logic              hit;
   logic [15:0]       age;

   // the table read is registered, so address it with the index of the next cycle
   assign rd_slot = idx_in;
   assign last    = (idx_ff == SlotW'(MaxProcs - 1));
   assign age     = seq_ff - rd_stamp;

   always_comb begin
      if (free_mode_ff) begin
         hit = (slot_state[idx_ff] == SLOT_FREE);
      end else begin
         hit = (slot_state[idx_ff] == SLOT_BLOCKED) && (rd_event == ev_ff);
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      age_in       = age_ff;
      free_mode_in = free_mode_ff;
      ev_in        = ev_ff;
      seq_in       = seq_ff;
      scan_rsp     = '{done: 1'b0, found: found_ff, slot: best_ff};
      if (scan_req.start && !busy_ff) begin
         busy_in      = 1'b1;
         idx_in       = '0;
         found_in     = 1'b0;
         free_mode_in = scan_req.find_free;
         ev_in        = scan_req.event_id;
         seq_in       = scan_req.block_seq;
      end else if (busy_ff) begin
         // free search keeps the first hit, unblock keeps the strictly younger one
         if (hit && (!found_ff || (!free_mode_ff && age < age_ff))) begin
            found_in = 1'b1;
            best_in  = idx_ff;
            age_in   = age;
         end
         idx_in = idx_ff + 1'b1;
         if (last) begin
            busy_in  = 1'b0;
            scan_rsp = '{done: 1'b1, found: found_in, slot: best_in};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         found_ff <= found_in;
      end
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      age_ff       <= age_in;
      free_mode_ff <= free_mode_in;
      ev_ff        <= ev_in;
      seq_ff       <= seq_in;
   end

`ifndef SYNTHESIS
   a_done_busy : assert property (@(posedge clock) disable iff (reset)
      scan_rsp.done |-> busy_ff)
      else $error("scan done while idle");
   a_done_found : assert property (@(posedge clock) disable iff (reset)
      scan_rsp.done && scan_rsp.found |-> slot_state[scan_rsp.slot] != SLOT_READY)
      else $error("scan picked a ready slot");
   a_done_end : assert property (@(posedge clock) disable iff (reset)
      scan_rsp.done |=> !busy_ff)
      else $error("scan did not stop");
`endif

endmodule

>>> rtl/core/process_state_scheduler.sv
// top level of the process state scheduler: sequencer, slot table and ready queue
// sequence: create and unblock go S_READ, S_SCAN (one slot a cycle in the scanner), S_EXEC,
//   S_WRITE, then rsp_valid in S_RESP; tick, block, done and unknown requests skip S_SCAN
// throughput: one transaction at a time; req_ready is low from acceptance until the result
//   is taken
// reset: synchronous, clears slot states, queue pointers, runner, ready count and block sequence; next pid is set to 1
module process_state_scheduler
   import pss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_req_type,
   input  logic [15:0] req_event_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_proc_id,
   output logic [31:0] rsp_cycle_total,
   output logic        rsp_dispatched
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_READ  = 6'b000010,
      S_SCAN  = 6'b000100,
      S_EXEC  = 6'b001000,
      S_WRITE = 6'b010000,
      S_RESP  = 6'b100000
   } fsm_type;

   fsm_type                     state_ff, state_in;
   slot_state_type [MaxProcs-1:0] slot_state_ff;
   logic [15:0]                 mem_pid   [MaxProcs];
   logic [31:0]                 mem_cyc   [MaxProcs];
   logic [15:0]                 mem_event [MaxProcs];
   logic [15:0]                 mem_stamp [MaxProcs];
   logic [SlotW-1:0]            fifo_mem  [MaxProcs];
   logic [SlotW-1:0]            head_ff, tail_ff;
   logic [CountW-1:0]           count_ff;
   logic                        run_valid_ff;
   logic [SlotW-1:0]            run_slot_ff;
   logic [15:0]                 next_pid_ff;
   logic [15:0]                 block_seq_ff;
   logic [2:0]                  op_ff;
   logic [15:0]                 ev_ff;
   logic [SlotW-1:0]            tgt_ff;
   logic                        disp_ff;
   logic [15:0]                 sc_event_ff, sc_stamp_ff;
   logic [SlotW-1:0]            sc_slot;
   logic [SlotW-1:0]            head_slot_ff;
   logic [2:0]                  st_ff;
   logic [15:0]                 pid_ff;
   logic [31:0]                 cyc_ff;
   scan_req_type                scan_req;
   scan_rsp_type                scan_rsp;

   assign req_ready       = state_ff == S_IDLE;
   assign rsp_valid       = state_ff == S_RESP;
   assign rsp_status      = st_ff;
   assign rsp_proc_id     = pid_ff;
   assign rsp_cycle_total = cyc_ff;
   assign rsp_dispatched  = disp_ff;

   assign scan_req = '{start: state_ff == S_READ
                          && (op_ff == REQ_CREATE || op_ff == REQ_UNBLOCK),
                       find_free: op_ff == REQ_CREATE,
                       event_id: ev_ff, block_seq: block_seq_ff};

   pss_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .scan_req   (scan_req),
      .slot_state (slot_state_ff),
      .rd_slot    (sc_slot),
      .rd_event   (sc_event_ff),
      .rd_stamp   (sc_stamp_ff),
      .scan_rsp   (scan_rsp)
   );

   // the scanner's event and stamp reads are registered ahead of its compare
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_READ;
         S_READ: begin
            if (op_ff == REQ_CREATE || op_ff == REQ_UNBLOCK) state_in = S_SCAN;
            else state_in = S_EXEC;
         end
         S_SCAN:  if (scan_rsp.done) state_in = S_EXEC;
         S_EXEC:  state_in = S_WRITE;
         S_WRITE: state_in = S_RESP;
         S_RESP:  if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // table ports: event/stamp read for the scanner, ready head read for a dispatch
   always_ff @(posedge clock) begin
      sc_event_ff  <= mem_event[sc_slot];
      sc_stamp_ff  <= mem_stamp[sc_slot];
      head_slot_ff <= fifo_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_state_ff <= {MaxProcs{SLOT_FREE}};
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         run_valid_ff  <= 1'b0;
         run_slot_ff   <= '0;
         next_pid_ff   <= 16'd1;
         block_seq_ff  <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_IDLE: begin
               op_ff   <= req_req_type;
               ev_ff   <= req_event_id;
               disp_ff <= 1'b0;
               st_ff   <= STAT_OK;
               pid_ff  <= '0;
               cyc_ff  <= '0;
            end
            S_READ: tgt_ff <= run_slot_ff;
            S_SCAN: if (scan_rsp.done) tgt_ff <= scan_rsp.slot;
            S_EXEC: begin
               case (op_ff)
                  REQ_CREATE: begin
                     if (!scan_rsp.found) st_ff <= STAT_TABLE_FULL;
                  end
                  REQ_TICK: begin
                     if (!run_valid_ff) begin
                        if (count_ff == '0) begin
                           st_ff <= STAT_NO_READY;
                        end else begin
                           tgt_ff  <= head_slot_ff;
                           disp_ff <= 1'b1;
                        end
                     end
                  end
                  REQ_BLOCK, REQ_DONE: if (!run_valid_ff) st_ff <= STAT_NO_RUNNING;
                  REQ_UNBLOCK: if (!scan_rsp.found) st_ff <= STAT_NO_MATCH;
                  default: ;
               endcase
            end
            default: ;
         endcase
         // commit happens on the S_WRITE to S_RESP edge
         if (state_ff == S_WRITE && st_ff == STAT_OK) begin
            case (op_ff)
               REQ_CREATE: begin
                  mem_pid[tgt_ff]       <= next_pid_ff;
                  mem_cyc[tgt_ff]       <= '0;
                  mem_event[tgt_ff]     <= '0;
                  slot_state_ff[tgt_ff] <= SLOT_READY;
                  fifo_mem[tail_ff]     <= tgt_ff;
                  tail_ff               <= tail_ff + 1'b1;
                  count_ff              <= count_ff + 1'b1;
                  next_pid_ff <= (next_pid_ff == 16'hFFFF) ? 16'd1 : next_pid_ff + 16'd1;
                  pid_ff                <= next_pid_ff;
               end
               REQ_TICK: begin
                  if (disp_ff) begin
                     head_ff      <= head_ff + 1'b1;
                     count_ff     <= count_ff - 1'b1;
                     run_slot_ff  <= tgt_ff;
                     run_valid_ff <= 1'b1;
                     slot_state_ff[tgt_ff] <= SLOT_RUNNING;
                  end
                  pid_ff <= mem_pid[tgt_ff];
                  cyc_ff <= (mem_cyc[tgt_ff] == '1) ? mem_cyc[tgt_ff]
                                                    : mem_cyc[tgt_ff] + 32'd1;
                  mem_cyc[tgt_ff] <= (mem_cyc[tgt_ff] == '1) ? mem_cyc[tgt_ff]
                                                             : mem_cyc[tgt_ff] + 32'd1;
               end
               REQ_BLOCK: begin
                  mem_event[tgt_ff]     <= ev_ff;
                  mem_stamp[tgt_ff]     <= block_seq_ff;
                  block_seq_ff          <= block_seq_ff + 16'd1;
                  slot_state_ff[tgt_ff] <= SLOT_BLOCKED;
                  run_valid_ff          <= 1'b0;
                  pid_ff                <= mem_pid[tgt_ff];
               end
               REQ_UNBLOCK: begin
                  slot_state_ff[tgt_ff] <= SLOT_READY;
                  fifo_mem[tail_ff]     <= tgt_ff;
                  tail_ff               <= tail_ff + 1'b1;
                  count_ff              <= count_ff + 1'b1;
                  pid_ff                <= mem_pid[tgt_ff];
               end
               REQ_DONE: begin
                  slot_state_ff[tgt_ff] <= SLOT_FREE;
                  run_valid_ff          <= 1'b0;
                  pid_ff                <= mem_pid[tgt_ff];
               end
               default: ;
            endcase
         end
      end
   end

`ifndef SYNTHESIS
   a_count_max : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(MaxProcs))
      else $error("ready count overflow");
   a_ok_pid : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_proc_id == '0)
      else $error("failing transaction carries a process id");
   a_disp_tick : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dispatched |-> run_valid_ff)
      else $error("dispatch without runner");
   a_run_state : assert property (@(posedge clock) disable iff (reset)
      run_valid_ff && state_ff == S_IDLE |-> slot_state_ff[run_slot_ff] == SLOT_RUNNING)
      else $error("runner slot not running");
`endif

endmodule
